/* rtl/core/aarm_pkg.sv */
// ---------------------------------------------------------------------------
// aarm_pkg
// shared widths, fixed-point constants and helper functions for the
// axis-angle to rotation matrix pipeline
// ---------------------------------------------------------------------------
package aarm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int IN_W         = FRAC_BITS + 4;
  localparam int OUT_W        = FRAC_BITS + 2;
  localparam int SQ_W         = 2 * IN_W;
  localparam int S_W          = SQ_W + 1;
  localparam int TH_W         = IN_W;
  localparam int SQRT_STEPS   = TH_W;
  localparam int QUO_W        = 31;
  localparam int R_W          = QUO_W + 1;
  localparam int Q_W          = 35;
  localparam int M_W          = Q_W + 1;
  localparam int TQ_SHIFT     = 30 - FRAC_BITS;
  localparam int CORDIC_ITERS = 16;

  localparam int DIV_LAT  = QUO_W + 2;
  localparam int COR_LAT  = CORDIC_ITERS + 2;
  localparam int COR_PAD  = DIV_LAT - COR_LAT;
  localparam int PIPE_LEN = 2 + SQRT_STEPS + DIV_LAT + 2;

  localparam logic signed [Q_W-1:0] ONE_Q30     = Q_W'(64'sd1073741824);
  localparam logic signed [Q_W-1:0] PI_Q30      = Q_W'(64'sd3373259426);
  localparam logic signed [Q_W-1:0] HALF_PI_Q30 = Q_W'(64'sd1686629713);
  localparam logic signed [Q_W-1:0] GAIN_Q30    = Q_W'(64'sd652032874);

  localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(1 << FRAC_BITS);

  localparam logic [30:0] ATAN_TAB [24] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255, 31'd127
  };

  function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] p,
                                                  input logic signed [R_W-1:0] q);
    logic signed [Q_W+R_W-1:0] prod;
    logic signed [Q_W+R_W-1:0] rnd;
    prod = p * q;
    rnd  = (prod + (Q_W+R_W)'(64'sd536870912)) >>> 30;
    return rnd[Q_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [M_W-1:0] v);
    logic signed [M_W-1:0] o;
    o = (v + M_W'(1 << (TQ_SHIFT - 1))) >>> TQ_SHIFT;
    if (o > M_W'(1 << FRAC_BITS)) begin
      o = M_W'(1 << FRAC_BITS);
    end else if (o < -M_W'(1 << FRAC_BITS)) begin
      o = -M_W'(1 << FRAC_BITS);
    end
    return o[OUT_W-1:0];
  endfunction

endpackage

/* rtl/core/aarm_if.sv */
// ---------------------------------------------------------------------------
// aarm channel interfaces
// valid/ready channels for rotation vectors and rotation matrices
// ---------------------------------------------------------------------------
interface aarm_in_if import aarm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] rot_x;
  logic signed [IN_W-1:0] rot_y;
  logic signed [IN_W-1:0] rot_z;

  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

interface aarm_out_if import aarm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] m00;
  logic signed [OUT_W-1:0] m10;
  logic signed [OUT_W-1:0] m20;
  logic signed [OUT_W-1:0] m01;
  logic signed [OUT_W-1:0] m11;
  logic signed [OUT_W-1:0] m21;
  logic signed [OUT_W-1:0] m02;
  logic signed [OUT_W-1:0] m12;
  logic signed [OUT_W-1:0] m22;

  modport source (output valid, m00, m10, m20, m01, m11, m21, m02, m12, m22,
                  input ready);
  modport sink   (input valid, m00, m10, m20, m01, m11, m21, m02, m12, m22,
                  output ready);
endinterface

/* rtl/core/axis_angle_to_rotation_matrix.sv */
// ---------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// rodrigues rotation formula: rotation vector in Q3.16, 3x3 matrix out in Q1.16
//
//   channel  dir  payload                          handshake
//   in_chan  in   rot_x rot_y rot_z (20b signed)   valid/ready
//   out_chan out  m00..m22 (18b signed)            valid/ready
//
// one request per cycle while the output is not stalled; pipeline stages
// (squares, sum, 20 root stages, 33 divider stages, two multiply stages)
// the quotient divider sets the depth; cordic runs alongside it
// reset clears only the valid bits; no state survives a request
// a stall at the output freezes the whole pipeline, nothing dropped or repeated
// ---------------------------------------------------------------------------
module axis_angle_to_rotation_matrix import aarm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  aarm_in_if.sink    in_chan,
  aarm_out_if.source out_chan
);

  logic adv;
  logic vld_r [PIPE_LEN];
  logic out_vld_r;

  logic signed [IN_W-1:0] in_x_ext, in_y_ext, in_z_ext;
  logic signed [SQ_W-1:0] ex_x, ex_y, ex_z;
  logic [SQ_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic signed [IN_W-1:0] v1_x_r, v1_y_r, v1_z_r;

  logic [S_W-1:0]         rem_r  [SQRT_STEPS+1];
  logic [TH_W-1:0]        root_r [SQRT_STEPS+1];
  logic signed [IN_W-1:0] vx_r   [SQRT_STEPS+1];
  logic signed [IN_W-1:0] vy_r   [SQRT_STEPS+1];
  logic signed [IN_W-1:0] vz_r   [SQRT_STEPS+1];

  logic [TH_W-1:0] th;
  logic            zero_d_r [DIV_LAT];
  logic signed [R_W-1:0] r1, r2, r3;
  logic signed [Q_W-1:0] cos_q, sin_q, omc_q;
  logic signed [Q_W-1:0] a_d_r [COR_PAD];
  logic signed [Q_W-1:0] b_d_r [COR_PAD];
  logic signed [Q_W-1:0] c_d_r [COR_PAD];

  logic signed [Q_W-1:0] pc1_r, pc2_r, pc3_r, pb1_r, pb2_r, pb3_r, a1_r;
  logic signed [R_W-1:0] r1_r, r2_r, r3_r;
  logic                  zero1_r;
  logic signed [Q_W-1:0] q11_r, q21_r, q31_r, q22_r, q32_r, q33_r;
  logic signed [Q_W-1:0] qb1_r, qb2_r, qb3_r, a2_r;
  logic                  zero2_r;
  logic signed [OUT_W-1:0] m_r [9];

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LEN; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_chan.valid;
      for (int k = 1; k < PIPE_LEN; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[PIPE_LEN-1];
    end
  end

  // squares
  assign in_x_ext = in_chan.rot_x;
  assign in_y_ext = in_chan.rot_y;
  assign in_z_ext = in_chan.rot_z;
  assign ex_x = SQ_W'(in_x_ext);
  assign ex_y = SQ_W'(in_y_ext);
  assign ex_z = SQ_W'(in_z_ext);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r <= SQ_W'(ex_x * ex_x);
      sq_y_r <= SQ_W'(ex_y * ex_y);
      sq_z_r <= SQ_W'(ex_z * ex_z);
      v1_x_r <= in_chan.rot_x;
      v1_y_r <= in_chan.rot_y;
      v1_z_r <= in_chan.rot_z;
      rem_r[0]  <= S_W'(sq_x_r) + S_W'(sq_y_r) + S_W'(sq_z_r);
      root_r[0] <= '0;
      vx_r[0]   <= v1_x_r;
      vy_r[0]   <= v1_y_r;
      vz_r[0]   <= v1_z_r;
    end
  end

  // integer square root, one root bit per stage
  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = SQRT_STEPS - k;
    logic [S_W:0] trial;
    logic         take;

    always_comb begin
      trial = ((S_W+1)'(root_r[k-1]) << (B + 1)) + ((S_W+1)'(1) << (2 * B));
      take  = {1'b0, rem_r[k-1]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= take ? S_W'({1'b0, rem_r[k-1]} - trial) : rem_r[k-1];
        root_r[k] <= root_r[k-1] | (TH_W'(take) << B);
        vx_r[k]   <= vx_r[k-1];
        vy_r[k]   <= vy_r[k-1];
        vz_r[k]   <= vz_r[k-1];
      end
    end
  end

  assign th = root_r[SQRT_STEPS];

  aarm_div u_div_x (
    .clk (clk), .en (adv), .th (th), .quo (r1),
    .mag (vx_r[SQRT_STEPS][IN_W-1] ? TH_W'(-vx_r[SQRT_STEPS]) : TH_W'(vx_r[SQRT_STEPS])),
    .neg (vx_r[SQRT_STEPS][IN_W-1])
  );
  aarm_div u_div_y (
    .clk (clk), .en (adv), .th (th), .quo (r2),
    .mag (vy_r[SQRT_STEPS][IN_W-1] ? TH_W'(-vy_r[SQRT_STEPS]) : TH_W'(vy_r[SQRT_STEPS])),
    .neg (vy_r[SQRT_STEPS][IN_W-1])
  );
  aarm_div u_div_z (
    .clk (clk), .en (adv), .th (th), .quo (r3),
    .mag (vz_r[SQRT_STEPS][IN_W-1] ? TH_W'(-vz_r[SQRT_STEPS]) : TH_W'(vz_r[SQRT_STEPS])),
    .neg (vz_r[SQRT_STEPS][IN_W-1])
  );

  aarm_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .th    (th),
    .cos_q (cos_q),
    .sin_q (sin_q),
    .omc_q (omc_q)
  );

  // line up cordic results and the zero flag with the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_d_r[0] <= th == '0;
      for (int k = 1; k < DIV_LAT; k++) begin
        zero_d_r[k] <= zero_d_r[k-1];
      end
      a_d_r[0] <= cos_q;
      b_d_r[0] <= sin_q;
      c_d_r[0] <= omc_q;
      for (int k = 1; k < COR_PAD; k++) begin
        a_d_r[k] <= a_d_r[k-1];
        b_d_r[k] <= b_d_r[k-1];
        c_d_r[k] <= c_d_r[k-1];
      end
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (adv) begin
      pc1_r   <= qmul(c_d_r[COR_PAD-1], r1);
      pc2_r   <= qmul(c_d_r[COR_PAD-1], r2);
      pc3_r   <= qmul(c_d_r[COR_PAD-1], r3);
      pb1_r   <= qmul(b_d_r[COR_PAD-1], r1);
      pb2_r   <= qmul(b_d_r[COR_PAD-1], r2);
      pb3_r   <= qmul(b_d_r[COR_PAD-1], r3);
      a1_r    <= a_d_r[COR_PAD-1];
      r1_r    <= r1;
      r2_r    <= r2;
      r3_r    <= r3;
      zero1_r <= zero_d_r[DIV_LAT-1];
    end
  end

  // second products
  always_ff @(posedge clk) begin
    if (adv) begin
      q11_r   <= qmul(pc1_r, r1_r);
      q21_r   <= qmul(pc2_r, r1_r);
      q31_r   <= qmul(pc3_r, r1_r);
      q22_r   <= qmul(pc2_r, r2_r);
      q32_r   <= qmul(pc3_r, r2_r);
      q33_r   <= qmul(pc3_r, r3_r);
      qb1_r   <= pb1_r;
      qb2_r   <= pb2_r;
      qb3_r   <= pb3_r;
      a2_r    <= a1_r;
      zero2_r <= zero1_r;
    end
  end

  // sums, rounding, saturation; identity matrix for a zero angle
  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero2_r) begin
        for (int k = 0; k < 9; k++) begin
          m_r[k] <= (k == 0 || k == 4 || k == 8) ? OUT_ONE : '0;
        end
      end else begin
        m_r[0] <= to_out(M_W'(a2_r) + M_W'(q11_r));
        m_r[1] <= to_out(M_W'(qb3_r) + M_W'(q21_r));
        m_r[2] <= to_out(M_W'(q31_r) - M_W'(qb2_r));
        m_r[3] <= to_out(M_W'(q21_r) - M_W'(qb3_r));
        m_r[4] <= to_out(M_W'(a2_r) + M_W'(q22_r));
        m_r[5] <= to_out(M_W'(qb1_r) + M_W'(q32_r));
        m_r[6] <= to_out(M_W'(qb2_r) + M_W'(q31_r));
        m_r[7] <= to_out(M_W'(q32_r) - M_W'(qb1_r));
        m_r[8] <= to_out(M_W'(a2_r) + M_W'(q33_r));
      end
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.m00   = m_r[0];
  assign out_chan.m10   = m_r[1];
  assign out_chan.m20   = m_r[2];
  assign out_chan.m01   = m_r[3];
  assign out_chan.m11   = m_r[4];
  assign out_chan.m21   = m_r[5];
  assign out_chan.m02   = m_r[6];
  assign out_chan.m12   = m_r[7];
  assign out_chan.m22   = m_r[8];

endmodule

/* rtl/core/aarm_div.sv */
// ---------------------------------------------------------------------------
// aarm_div
// pipelined restoring divider, one quotient bit per stage, gives the
// rounded signed axis component |v|*2^30/th in Q30
// ---------------------------------------------------------------------------
module aarm_div import aarm_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TH_W-1:0]       mag,
  input  logic                  neg,
  input  logic [TH_W-1:0]       th,
  output logic signed [R_W-1:0] quo
);

  logic [TH_W-1:0]  rem_r  [QUO_W+1];
  logic [QUO_W-1:0] low_r  [QUO_W+1];
  logic [QUO_W-1:0] q_r    [QUO_W+1];
  logic [TH_W-1:0]  th_r   [QUO_W+1];
  logic             neg_r  [QUO_W+1];
  logic signed [R_W-1:0] quo_r;

  // numerator is mag*2^30 + th/2, which is a plain concatenation
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag >> 1;
      low_r[0] <= {mag[0], (QUO_W-1)'(th >> 1)};
      q_r[0]   <= '0;
      th_r[0]  <= th;
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
    logic [TH_W:0]   trial;
    logic            take;
    logic [TH_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[j-1], low_r[j-1][QUO_W-1]};
      take    = trial >= {1'b0, th_r[j-1]};
      rem_nxt = take ? TH_W'(trial - {1'b0, th_r[j-1]}) : trial[TH_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        low_r[j] <= low_r[j-1] << 1;
        q_r[j]   <= {q_r[j-1][QUO_W-2:0], take};
        th_r[j]  <= th_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[QUO_W] ? -$signed({1'b0, q_r[QUO_W]}) : $signed({1'b0, q_r[QUO_W]});
    end
  end

  assign quo = quo_r;

endmodule

/* rtl/core/aarm_cordic.sv */
// ---------------------------------------------------------------------------
// aarm_cordic
// pipelined rotation-mode cordic, one iteration per stage, gives
// cos, sin and 1-cos of the angle th in Q30
// ---------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TH_W-1:0]       th,
  output logic signed [Q_W-1:0] cos_q,
  output logic signed [Q_W-1:0] sin_q,
  output logic signed [Q_W-1:0] omc_q
);

  logic signed [Q_W-1:0] x_r   [CORDIC_ITERS+1];
  logic signed [Q_W-1:0] y_r   [CORDIC_ITERS+1];
  logic signed [Q_W-1:0] z_r   [CORDIC_ITERS+1];
  logic                  neg_r [CORDIC_ITERS+1];
  logic                  big_r [CORDIC_ITERS+1];
  logic signed [Q_W-1:0] tq;
  logic signed [Q_W-1:0] cos_r, sin_r, omc_r;
  logic signed [Q_W-1:0] a_nxt;

  assign tq = $signed(Q_W'(th) << TQ_SHIFT);

  // fold into the first quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= (tq > HALF_PI_Q30) ? PI_Q30 - tq : tq;
      neg_r[0] <= tq > HALF_PI_Q30;
      big_r[0] <= tq >= PI_Q30;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [Q_W-1:0] dx, dy, at;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      at = $signed({{(Q_W-31){1'b0}}, ATAN_TAB[i]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][Q_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
        neg_r[i+1] <= neg_r[i];
        big_r[i+1] <= big_r[i];
      end
    end
  end

  always_comb begin
    if (big_r[CORDIC_ITERS]) begin
      a_nxt = -ONE_Q30;
    end else if (neg_r[CORDIC_ITERS]) begin
      a_nxt = -x_r[CORDIC_ITERS];
    end else begin
      a_nxt = x_r[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= a_nxt;
      sin_r <= big_r[CORDIC_ITERS] ? '0 : y_r[CORDIC_ITERS];
      omc_r <= ONE_Q30 - a_nxt;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;
  assign omc_q = omc_r;

endmodule

/* test/aarm_tb_if.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aarm testbench channel note
// the channel interfaces come from the rtl; this file only adds a shared
// request record used by the testbench driver and predictor, and a matrix
// record used by the predictor and monitor
package aarm_tb_pkg;
  import aarm_pkg::*;

  typedef struct packed {
    logic signed [IN_W-1:0] rot_x;
    logic signed [IN_W-1:0] rot_y;
    logic signed [IN_W-1:0] rot_z;
  } rot_vec_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m22;
  } rot_mat_t;
endpackage

/* test/axis_angle_to_rotation_matrix_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_tb
// drives rotation vectors through the converter with random gaps and
// back-pressure, predicts each matrix in 64-bit fixed point and compares
// all nine entries in order
// ---------------------------------------------------------------------------
module axis_angle_to_rotation_matrix_tb;
  import aarm_pkg::*;
  import aarm_tb_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aarm_in_if  in_chan ();
  aarm_out_if out_chan ();

  axis_angle_to_rotation_matrix i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  always #5 clk = ~clk;

  rot_vec_t pending_vecs[$];
  rot_mat_t expected_mats[$];
  int  errors = 0;
  bit  src_noidle = 1'b0;
  bit  snk_noidle = 1'b0;
  bit  hold_sink = 1'b0;
  int  hold_cnt = 0;
  bit  start_hold = 1'b0;
  int  quiet_cycles = 0;

  localparam longint ATAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint p, longint q);
    return floor_shift(p * q + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint unit_comp(longint v, longint th);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = ((mag <<< 30) + th / 2) / th;
    return (v < 0) ? -r : r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(longint v);
    longint o, lim;
    lim = 64'sd1 <<< FRAC_BITS;
    o = floor_shift(v + (64'sd1 <<< (29 - FRAC_BITS)), 30 - FRAC_BITS);
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    return o[OUT_W-1:0];
  endfunction

  function automatic rot_mat_t rodrigues(rot_vec_t v);
    longint vx, vy, vz, sq, th, tq, r1, r2, r3, a, b, c, x, y, z, dx, dy;
    longint m[9];
    longint rem, root, bitv;
    bit neg;
    rot_mat_t res;
    vx = v.rot_x; vy = v.rot_y; vz = v.rot_z;
    sq = vx * vx + vy * vy + vz * vz;
    if (sq == 0) begin
      m = '{64'sd1 <<< 30, 0, 0, 0, 64'sd1 <<< 30, 0, 0, 0, 64'sd1 <<< 30};
    end else begin
      rem = sq; root = 0; bitv = 64'sd1 <<< 62;
      while (bitv > rem) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >>> 1) + bitv;
        end else begin
          root = root >>> 1;
        end
        bitv = bitv >>> 2;
      end
      th = root;
      tq = th <<< (30 - FRAC_BITS);
      r1 = unit_comp(vx, th); r2 = unit_comp(vy, th); r3 = unit_comp(vz, th);
      if (tq >= 64'sd3373259426) begin
        a = -(64'sd1 <<< 30);
        b = 0;
      end else begin
        neg = 1'b0; x = 652032874; y = 0; z = tq;
        if (z > 64'sd1686629713) begin
          z = 64'sd3373259426 - z;
          neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
          dx = floor_shift(y, i); dy = floor_shift(x, i);
          if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_Q30[i];
          end else begin
            x += dx; y -= dy; z += ATAN_Q30[i];
          end
        end
        a = neg ? -x : x;
        b = y;
      end
      c = (64'sd1 <<< 30) - a;
      m[0] = a + q30_mul(q30_mul(c, r1), r1);
      m[1] = q30_mul(b, r3) + q30_mul(q30_mul(c, r2), r1);
      m[2] = -q30_mul(b, r2) + q30_mul(q30_mul(c, r3), r1);
      m[3] = -q30_mul(b, r3) + q30_mul(q30_mul(c, r2), r1);
      m[4] = a + q30_mul(q30_mul(c, r2), r2);
      m[5] = q30_mul(b, r1) + q30_mul(q30_mul(c, r3), r2);
      m[6] = q30_mul(b, r2) + q30_mul(q30_mul(c, r3), r1);
      m[7] = -q30_mul(b, r1) + q30_mul(q30_mul(c, r3), r2);
      m[8] = a + q30_mul(q30_mul(c, r3), r3);
    end
    res.m00 = sat_out(m[0]); res.m10 = sat_out(m[1]); res.m20 = sat_out(m[2]);
    res.m01 = sat_out(m[3]); res.m11 = sat_out(m[4]); res.m21 = sat_out(m[5]);
    res.m02 = sat_out(m[6]); res.m12 = sat_out(m[7]); res.m22 = sat_out(m[8]);
    return res;
  endfunction

  function automatic rot_vec_t mk_vec(int x, int y, int z);
    rot_vec_t v;
    v.rot_x = x[IN_W-1:0]; v.rot_y = y[IN_W-1:0]; v.rot_z = z[IN_W-1:0];
    return v;
  endfunction

  function automatic int rand_comp(int mode);
    case (mode)
      0: return $urandom_range(0, 1 << IN_W) - (1 << (IN_W - 1));
      1: return int'($urandom_range(0, 2 * 205887)) - 205887;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return ($urandom_range(0, 1)) ? 524287 : -524288;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_vecs.size() != 0 &&
          (src_noidle || $urandom_range(0, 99) >= 28)) begin
        in_chan.valid <= 1'b1;
        {in_chan.rot_x, in_chan.rot_y, in_chan.rot_z} <= pending_vecs.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      expected_mats.push_back(rodrigues({in_chan.rot_x, in_chan.rot_y, in_chan.rot_z}));
    end
  end

  // receiver ready and long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (start_hold && !hold_sink) begin
      hold_sink <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_chan.ready <= 1'b0;
    end else if (hold_sink) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) begin
        hold_sink <= 1'b0;
      end
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= snk_noidle || ($urandom_range(0, 99) >= 28);
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_mat_t exp_m, got_m;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_m = {out_chan.m00, out_chan.m10, out_chan.m20, out_chan.m01, out_chan.m11,
               out_chan.m21, out_chan.m02, out_chan.m12, out_chan.m22};
      if (expected_mats.size() == 0) begin
        errors++;
        $display("%0t unexpected matrix %h", $time, got_m);
      end else begin
        exp_m = expected_mats.pop_front();
        if (exp_m !== got_m) begin
          errors++;
          $display("%0t mismatch exp m00..m22 %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                   $time, exp_m.m00, exp_m.m10, exp_m.m20, exp_m.m01, exp_m.m11,
                   exp_m.m21, exp_m.m02, exp_m.m12, exp_m.m22);
          $display("%0t          got m00..m22 %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                   $time, got_m.m00, got_m.m10, got_m.m20, got_m.m01, got_m.m11,
                   got_m.m21, got_m.m02, got_m.m12, got_m.m22);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n && (pending_vecs.size() != 0 || in_chan.valid ||
                           expected_mats.size() != 0)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("[axis_angle_to_rotation_matrix] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_vecs.size() != 0 || in_chan.valid || expected_mats.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int mode;
    in_chan.valid = 1'b0;
    in_chan.rot_x = '0; in_chan.rot_y = '0; in_chan.rot_z = '0;
    out_chan.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, extremes, pi boundary, axes, tiny angles
    pending_vecs.push_back(mk_vec(0, 0, 0));
    pending_vecs.push_back(mk_vec(1, 0, 0));
    pending_vecs.push_back(mk_vec(0, -1, 0));
    pending_vecs.push_back(mk_vec(524287, 0, 0));
    pending_vecs.push_back(mk_vec(0, -524288, 0));
    pending_vecs.push_back(mk_vec(0, 0, 524287));
    pending_vecs.push_back(mk_vec(524287, 524287, 524287));
    pending_vecs.push_back(mk_vec(-524288, -524288, -524288));
    pending_vecs.push_back(mk_vec(205887, 0, 0));
    pending_vecs.push_back(mk_vec(0, 205888, 0));
    pending_vecs.push_back(mk_vec(0, 0, -205886));
    pending_vecs.push_back(mk_vec(102943, 0, 0));
    pending_vecs.push_back(mk_vec(0, 102944, 0));
    pending_vecs.push_back(mk_vec(118870, 118870, 118870));
    pending_vecs.push_back(mk_vec(3, 4, 12));
    pending_vecs.push_back(mk_vec(1, 1, 1));
    pending_vecs.push_back(mk_vec(-7, 5, -3));
    pending_vecs.push_back(mk_vec(40000, -30000, 12000));
    pending_vecs.push_back(mk_vec(-65536, 65536, -65536));
    pending_vecs.push_back(mk_vec(145582, 145582, 0));
    wait_drained();

    // no idling stretch
    src_noidle = 1'b1; snk_noidle = 1'b1;
    repeat (120) pending_vecs.push_back(mk_vec(rand_comp(1), rand_comp(1), rand_comp(1)));
    wait_drained();
    src_noidle = 1'b0; snk_noidle = 1'b0;

    // sink holds off while source keeps offering
    repeat (150) pending_vecs.push_back(mk_vec(rand_comp(0), rand_comp(0), rand_comp(0)));
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    wait_drained();

    repeat (360) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 1 : (mode < 8) ? 0 : (mode < 9) ? 2 : 3;
      pending_vecs.push_back(mk_vec(rand_comp(mode), rand_comp(mode), rand_comp(mode)));
    end
    wait_drained();
    repeat (PIPE_LEN + 20) @(posedge clk);

    if (errors == 0) begin
      $display("[axis_angle_to_rotation_matrix] OK");
    end else begin
      $display("[axis_angle_to_rotation_matrix] ERROR");
    end
    $finish;
  end
endmodule
